@@ hw/rtl/hjbd_pkg.sv @@
// hjbd_pkg: types, constants and register indexes for the headset jack and button detector
// no dependencies; imported by headset_jack_and_button_detect_top
`timescale 1ns / 1ps

package hjbd_pkg;

    localparam int NUM_KEYS  = 3;
    localparam int MV_W      = 12;
    localparam int WORD_W    = 16;
    localparam int STATUS_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int KEY_BIT0  = 2;

    localparam logic [WORD_W-1:0] WORD_INSERTION       = 16'h80FB;
    localparam logic [WORD_W-1:0] WORD_REMOVAL_HEADSET = 16'hC0F3;
    localparam logic [WORD_W-1:0] WORD_REMOVAL_HOOK    = 16'hCAF3;
    localparam logic [WORD_W-1:0] WORD_HOOK_RELEASE    = 16'hC2F3;

    localparam logic [MV_W-1:0] HP_CLASS_MAX_MV     = 12'd70;
    localparam logic [MV_W-1:0] REMOVED_OPEN_MIN_MV = 12'd1800;

    localparam logic [MV_W-1:0] RST_KEY0_LOW    = 12'd0;
    localparam logic [MV_W-1:0] RST_KEY0_HIGH   = 12'd100;
    localparam logic [MV_W-1:0] RST_KEY1_LOW    = 12'd130;
    localparam logic [MV_W-1:0] RST_KEY1_HIGH   = 12'd150;
    localparam logic [MV_W-1:0] RST_KEY2_LOW    = 12'd275;
    localparam logic [MV_W-1:0] RST_KEY2_HIGH   = 12'd325;
    localparam logic [MV_W-1:0] RST_HEADSET_LOW  = 12'd475;
    localparam logic [MV_W-1:0] RST_HEADSET_HIGH = 12'd2800;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2_HIGH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADSET_LOW  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADSET_HIGH = 3'd7;

    localparam logic [1:0] JACK_BITS_NONE      = 2'd0;
    localparam logic [1:0] JACK_BITS_HEADPHONE = 2'd1;
    localparam logic [1:0] JACK_BITS_HEADSET   = 2'd3;

    typedef enum logic [1:0] {
        CLS_REMOVED   = 2'd0,
        CLS_HEADSET   = 2'd1,
        CLS_HEADPHONE = 2'd2,
        CLS_INVALID   = 2'd3
    } t_class;

    typedef struct packed {
        logic            func;
        logic [MV_W-1:0] sample_mv;
        logic            plug_sense;
    } t_in;

    typedef struct packed {
        logic                detect_write;
        logic [WORD_W-1:0]   detect_word;
        logic                report_valid;
        logic [STATUS_W-1:0] report_status;
        logic [STATUS_W-1:0] report_mask;
        logic [1:0]          accessory_code;
    } t_out;

endpackage

@@ hw/rtl/headset_jack_and_button_detect_top.sv @@
// headset_jack_and_button_detect_top: jack classification, pair filter and button windows
// depends on hjbd_pkg
`timescale 1ns / 1ps

// Usage
// Input channel i_valid / i_data / o_stall carries one detect sample per transaction:
// func (0 jack, 1 button), sample_mv and plug_sense. A transaction is taken at a rising
// edge with i_valid high and o_stall low.
// Output channel o_valid / o_data / i_stall returns exactly one result per input
// transaction, in order, taken at an edge with o_valid high and i_stall low.
// The result of an accepted sample is registered. Throughput is one sample per cycle while
// o_stall is low; classification, the pair filter and the key window compares are one pass
// of compare logic feeding the result register.
// When the receiver stalls, the result register holds and one more result goes into a skid
// register; o_stall rises only while it is full. The user must write threshold registers
// via i_cfg_we / i_cfg_index / i_cfg_data only while idle; the block does not enforce it.
// Reset (synchronous, active low) restores the default thresholds, clears the pair filter,
// reported bits, key state and accessory code, and empties both result registers.
module headset_jack_and_button_detect_top
    import hjbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MV_W-1:0]      i_cfg_data,
    input  logic                 i_valid,
    input  t_in                  i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output t_out                 o_data,
    input  logic                 i_stall
);

    logic [MV_W-1:0]     r_key_low  [NUM_KEYS];
    logic [MV_W-1:0]     r_key_high [NUM_KEYS];
    logic [MV_W-1:0]     r_headset_low;
    logic [MV_W-1:0]     r_headset_high;

    logic                r_pair_second, n_pair_second;
    t_class              r_first_class, n_first_class;
    logic [STATUS_W-1:0] r_jack_bits,   n_jack_bits;
    logic                r_buttons_on,  n_buttons_on;
    logic [NUM_KEYS-1:0] r_key_down,    n_key_down;
    t_class              r_accessory,   n_accessory;

    logic                r_out_valid;
    t_out                r_out;
    logic                r_skid_valid;
    t_out                r_skid;

    t_out                n_res;
    t_class              cls;
    logic                in_acc;
    logic                out_take;

    assign in_acc   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low[0]   <= RST_KEY0_LOW;
            r_key_high[0]  <= RST_KEY0_HIGH;
            r_key_low[1]   <= RST_KEY1_LOW;
            r_key_high[1]  <= RST_KEY1_HIGH;
            r_key_low[2]   <= RST_KEY2_LOW;
            r_key_high[2]  <= RST_KEY2_HIGH;
            r_headset_low  <= RST_HEADSET_LOW;
            r_headset_high <= RST_HEADSET_HIGH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY0_LOW:     r_key_low[0]   <= i_cfg_data;
                CFG_KEY0_HIGH:    r_key_high[0]  <= i_cfg_data;
                CFG_KEY1_LOW:     r_key_low[1]   <= i_cfg_data;
                CFG_KEY1_HIGH:    r_key_high[1]  <= i_cfg_data;
                CFG_KEY2_LOW:     r_key_low[2]   <= i_cfg_data;
                CFG_KEY2_HIGH:    r_key_high[2]  <= i_cfg_data;
                CFG_HEADSET_LOW:  r_headset_low  <= i_cfg_data;
                CFG_HEADSET_HIGH: r_headset_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classification
    always_comb begin
        if (i_data.sample_mv >= r_headset_low && i_data.sample_mv <= r_headset_high
                && !i_data.plug_sense) begin
            cls = CLS_HEADSET;
        end else if (i_data.sample_mv <= HP_CLASS_MAX_MV && !i_data.plug_sense) begin
            cls = CLS_HEADPHONE;
        end else if (i_data.sample_mv > r_headset_high
                || (i_data.sample_mv > REMOVED_OPEN_MIN_MV && i_data.plug_sense)) begin
            cls = CLS_REMOVED;
        end else begin
            cls = CLS_INVALID;
        end
    end

    // per-transaction state update and result
    always_comb begin
        logic                found;
        logic [STATUS_W-1:0] bit_sel;
        logic [WORD_W-1:0]   word;
        logic [1:0]          bits;
        logic                btn_on;

        n_pair_second = r_pair_second;
        n_first_class = r_first_class;
        n_jack_bits   = r_jack_bits;
        n_buttons_on  = r_buttons_on;
        n_key_down    = r_key_down;
        n_accessory   = r_accessory;
        n_res         = '0;
        found         = 1'b0;
        bit_sel       = '0;
        word          = WORD_INSERTION;
        bits          = JACK_BITS_NONE;
        btn_on        = 1'b0;

        if (!i_data.func || r_jack_bits[1:0] != JACK_BITS_HEADSET) begin
            if (!r_pair_second) begin
                n_first_class = cls;
                n_pair_second = 1'b1;
            end else begin
                n_pair_second = 1'b0;
                if (cls == r_first_class) begin
                    unique case (cls)
                        CLS_HEADPHONE: begin
                            word = WORD_REMOVAL_HEADSET; bits = JACK_BITS_HEADPHONE;
                        end
                        CLS_HEADSET: begin
                            word = WORD_REMOVAL_HOOK; bits = JACK_BITS_HEADSET;
                            btn_on = 1'b1;
                        end
                        default: begin
                            word = WORD_INSERTION; bits = JACK_BITS_NONE;
                        end
                    endcase
                    n_accessory = cls;
                    if (cls != CLS_INVALID) begin
                        n_buttons_on = btn_on;
                        if (bits != r_jack_bits[1:0]) begin
                            n_res.detect_write  = 1'b1;
                            n_res.detect_word   = word;
                            n_res.report_valid  = 1'b1;
                            n_res.report_status = {{(STATUS_W-2){1'b0}}, bits};
                            n_res.report_mask   = {{(STATUS_W-2){1'b0}}, 2'b11};
                            n_jack_bits[1:0]    = bits;
                        end
                    end
                end
            end
        end else if (r_buttons_on) begin
            for (int i = 0; i < NUM_KEYS; i++) begin
                if (!found && i_data.sample_mv >= r_key_low[i]
                        && i_data.sample_mv <= r_key_high[i]) begin
                    found         = 1'b1;
                    n_key_down[i] = 1'b1;
                    bit_sel       = STATUS_W'(1 << (KEY_BIT0 + i));
                end
            end
            if (found) begin
                n_res.detect_write  = 1'b1;
                n_res.detect_word   = WORD_HOOK_RELEASE;
                n_res.report_valid  = 1'b1;
                n_res.report_status = bit_sel;
                n_res.report_mask   = bit_sel;
                n_jack_bits         = r_jack_bits | bit_sel;
            end else begin
                // release all, report the highest pressed key
                for (int i = 0; i < NUM_KEYS; i++) begin
                    if (r_key_down[i]) begin
                        found   = 1'b1;
                        bit_sel = STATUS_W'(1 << (KEY_BIT0 + i));
                    end
                end
                n_key_down = '0;
                if (found) begin
                    n_res.detect_write  = 1'b1;
                    n_res.detect_word   = WORD_REMOVAL_HOOK;
                    n_res.report_valid  = 1'b1;
                    n_res.report_status = '0;
                    n_res.report_mask   = bit_sel;
                    n_jack_bits         = r_jack_bits & ~bit_sel;
                end
            end
        end

        n_res.accessory_code = n_accessory;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_second <= 1'b0;
            r_first_class <= CLS_REMOVED;
            r_jack_bits   <= '0;
            r_buttons_on  <= 1'b0;
            r_key_down    <= '0;
            r_accessory   <= CLS_REMOVED;
        end else if (in_acc) begin
            r_pair_second <= n_pair_second;
            r_first_class <= n_first_class;
            r_jack_bits   <= n_jack_bits;
            r_buttons_on  <= n_buttons_on;
            r_key_down    <= n_key_down;
            r_accessory   <= n_accessory;
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_acc;
            end
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= n_res;
            end
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while result register empty");

    a_buttons_need_headset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buttons_on |-> (r_jack_bits[1:0] == JACK_BITS_HEADSET))
        else $error("buttons enabled without headset reported");

    a_jack_bits_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_jack_bits[1:0] != 2'b10)
        else $error("mic reported without headphone");

    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.report_valid) |->
            (r_out.report_mask == '0 && !r_out.detect_write))
        else $error("result carries data without a report");

endmodule
